// ===== sv/qrm_pkg.sv =====
package qrm_pkg;

  // Field widths
  localparam int IN_W   = 16;
  localparam int OUT_W  = 19;
  localparam int PROD_W = 2 * IN_W;

  // Matrix entries, row-major
  localparam int NUM_ENT = 9;
  typedef logic [3:0] ent_idx_t;

  localparam ent_idx_t ENT_R0C0 = 4'd0;
  localparam ent_idx_t ENT_R0C1 = 4'd1;
  localparam ent_idx_t ENT_R0C2 = 4'd2;
  localparam ent_idx_t ENT_R1C0 = 4'd3;
  localparam ent_idx_t ENT_R1C1 = 4'd4;
  localparam ent_idx_t ENT_R1C2 = 4'd5;
  localparam ent_idx_t ENT_R2C0 = 4'd6;
  localparam ent_idx_t ENT_R2C1 = 4'd7;
  localparam ent_idx_t ENT_R2C2 = 4'd8;

  // The nine distinct component products
  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] rx;
    logic signed [PROD_W-1:0] ry;
    logic signed [PROD_W-1:0] rz;
  } prod_t;

endpackage

// ===== sv/qrm_if.sv =====
interface qrm_quat_if import qrm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] quat_real;
  logic signed [IN_W-1:0] quat_i;
  logic signed [IN_W-1:0] quat_j;
  logic signed [IN_W-1:0] quat_k;

  modport source (output valid, quat_real, quat_i, quat_j, quat_k, input ready);
  modport sink (input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

interface qrm_mat_if import qrm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] row0_col0;
  logic signed [OUT_W-1:0] row0_col1;
  logic signed [OUT_W-1:0] row0_col2;
  logic signed [OUT_W-1:0] row1_col0;
  logic signed [OUT_W-1:0] row1_col1;
  logic signed [OUT_W-1:0] row1_col2;
  logic signed [OUT_W-1:0] row2_col0;
  logic signed [OUT_W-1:0] row2_col1;
  logic signed [OUT_W-1:0] row2_col2;

  modport source (
    output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    input  ready
  );
  modport sink (
    input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    output ready
  );
endinterface

// ===== sv/qrm_product_stage.sv =====
module qrm_product_stage import qrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrm_quat_if.sink   quat_i,
  input  logic       ready_i,
  output logic       valid_o,
  output prod_t      prod_o
);

  logic  valid_q;
  prod_t prod_d, prod_q;

  always_comb begin
    prod_d.xx = quat_i.quat_i    * quat_i.quat_i;
    prod_d.yy = quat_i.quat_j    * quat_i.quat_j;
    prod_d.zz = quat_i.quat_k    * quat_i.quat_k;
    prod_d.xy = quat_i.quat_i    * quat_i.quat_j;
    prod_d.xz = quat_i.quat_i    * quat_i.quat_k;
    prod_d.yz = quat_i.quat_j    * quat_i.quat_k;
    prod_d.rx = quat_i.quat_real * quat_i.quat_i;
    prod_d.ry = quat_i.quat_real * quat_i.quat_j;
    prod_d.rz = quat_i.quat_real * quat_i.quat_k;
  end

  // Take a new transaction when empty or when the next stage drains this one
  assign quat_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (quat_i.ready) begin
      valid_q <= quat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quat_i.valid && quat_i.ready) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== sv/qrm_sum_stage.sv =====
module qrm_sum_stage import qrm_pkg::*; #(
  parameter int FRAC_BITS = 15,
  parameter int ACC_W     = 35
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  prod_t                   prod_i,
  input  logic                    ready_i,
  output logic                    valid_o,
  output logic signed [ACC_W-1:0] sum_o [NUM_ENT]
);

  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) <<< (2 * FRAC_BITS);

  logic                    valid_q;
  logic signed [ACC_W-1:0] sum_d [NUM_ENT];
  logic signed [ACC_W-1:0] sum_q [NUM_ENT];
  logic signed [ACC_W-1:0] xx2, yy2, zz2, xy2, xz2, yz2, rx2, ry2, rz2;

  // Doubled products, sign-extended to the accumulator width
  always_comb begin
    xx2 = ACC_W'(prod_i.xx) <<< 1;
    yy2 = ACC_W'(prod_i.yy) <<< 1;
    zz2 = ACC_W'(prod_i.zz) <<< 1;
    xy2 = ACC_W'(prod_i.xy) <<< 1;
    xz2 = ACC_W'(prod_i.xz) <<< 1;
    yz2 = ACC_W'(prod_i.yz) <<< 1;
    rx2 = ACC_W'(prod_i.rx) <<< 1;
    ry2 = ACC_W'(prod_i.ry) <<< 1;
    rz2 = ACC_W'(prod_i.rz) <<< 1;

    sum_d[ENT_R0C0] = ONE - yy2 - zz2;
    sum_d[ENT_R0C1] = xy2 + rz2;
    sum_d[ENT_R0C2] = xz2 - ry2;
    sum_d[ENT_R1C0] = xy2 - rz2;
    sum_d[ENT_R1C1] = ONE - xx2 - zz2;
    sum_d[ENT_R1C2] = yz2 + rx2;
    sum_d[ENT_R2C0] = xz2 + ry2;
    sum_d[ENT_R2C1] = yz2 - rx2;
    sum_d[ENT_R2C2] = ONE - xx2 - yy2;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

// ===== sv/qrm_round_stage.sv =====
module qrm_round_stage import qrm_pkg::*; #(
  parameter int FRAC_BITS = 15,
  parameter int ACC_W     = 35
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [ACC_W-1:0] sum_i [NUM_ENT],
  qrm_mat_if.source               mat_o
);

  localparam int QW = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [QW-1:0]    QMAX = QW'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [QW-1:0]    QMIN = -QW'(2 ** (OUT_W - 1));

  logic                    valid_q;
  logic signed [ACC_W-1:0] rnd [NUM_ENT];
  logic signed [QW-1:0]    quo [NUM_ENT];
  logic signed [OUT_W-1:0] res_d [NUM_ENT];

  // Round half up, drop the fraction (floor), then clamp to the output range
  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      rnd[e] = sum_i[e] + HALF;
      quo[e] = rnd[e][ACC_W-1:FRAC_BITS];
      if (quo[e] > QMAX) begin
        res_d[e] = OUT_W'(QMAX);
      end else if (quo[e] < QMIN) begin
        res_d[e] = OUT_W'(QMIN);
      end else begin
        res_d[e] = quo[e][OUT_W-1:0];
      end
    end
  end

  assign ready_o     = !valid_q || mat_o.ready;
  assign mat_o.valid = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mat_o.row0_col0 <= res_d[ENT_R0C0];
      mat_o.row0_col1 <= res_d[ENT_R0C1];
      mat_o.row0_col2 <= res_d[ENT_R0C2];
      mat_o.row1_col0 <= res_d[ENT_R1C0];
      mat_o.row1_col1 <= res_d[ENT_R1C1];
      mat_o.row1_col2 <= res_d[ENT_R1C2];
      mat_o.row2_col0 <= res_d[ENT_R2C0];
      mat_o.row2_col1 <= res_d[ENT_R2C1];
      mat_o.row2_col2 <= res_d[ENT_R2C2];
    end
  end

endmodule

// ===== sv/quaternion_to_rotation_matrix_unit.sv =====
// Quaternion to 3x3 rotation matrix.
//
// Input channel in_i carries one quaternion per transaction: quat_real, quat_i,
// quat_j, quat_k, signed fixed point with FRAC_BITS fraction bits. Output
// channel out_o carries the nine matrix entries row0_col0..row2_col2, signed
// 19-bit with FRAC_BITS fraction bits, rounded half up and clamped to range.
// Both channels use valid/ready; a transaction moves when both are high.
//
// Pipeline: products, sums, round/clamp; three register stages. Each result
// is registered in the product, sum and round stages in turn and is then
// held on out_o until taken. Throughput is one transaction per clock while
// out_o.ready is high; stage 1 is a multiply level, stages 2 and 3 add/compare logic.
//
// Reset clears the valid bit of every stage; the data registers are not reset.
// When the receiver holds out_o.ready low, each stage keeps its transaction
// and fills from the one behind it; in_i.ready drops only once all three
// stages hold a transaction, so no transaction is lost or repeated.
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qrm_quat_if.sink  in_i,
  qrm_mat_if.source out_o
);

  // Accumulator must hold 1.0 at double precision plus the doubled products
  localparam int ACC_W = (2 * FRAC_BITS + 3 > PROD_W + 3) ? 2 * FRAC_BITS + 3 : PROD_W + 3;

  logic                    s1_valid, s1_ready;
  prod_t                   s1_prod;
  logic                    s2_valid, s2_ready;
  logic signed [ACC_W-1:0] s2_sum [NUM_ENT];

  // Stage 1: nine component products
  qrm_product_stage u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quat_i  (in_i),
    .ready_i (s1_ready),
    .valid_o (s1_valid),
    .prod_o  (s1_prod)
  );

  // Stage 2: form each entry exactly at double precision
  qrm_sum_stage #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .prod_i  (s1_prod),
    .ready_i (s2_ready),
    .valid_o (s2_valid),
    .sum_o   (s2_sum)
  );

  // Stage 3: round, clamp and hold as the output register
  qrm_round_stage #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .sum_i   (s2_sum),
    .mat_o   (out_o)
  );

  // An accepted quaternion always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_valid)
    else $error("accepted transaction missing from product stage");

  // The input only backs up when the whole pipeline is full
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid && s2_valid && out_o.valid)
    else $error("input stalled with a bubble in the pipeline");

  // A stalled product stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_prod))
    else $error("product stage dropped or changed a stalled transaction");

  // A stalled sum stage keeps its transaction (checked on entries R0C0 and R2C2)
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2_sum[ENT_R0C0])
      && $stable(s2_sum[ENT_R2C2]))
    else $error("sum stage dropped or changed a stalled transaction");

endmodule
